FILE: design/aarp_pkg.sv
// Shared types and opcode constants for the active address round-robin poller.
package aarp_pkg;

   // Width of the active map; addresses at or above this are never stored.
   localparam int unsigned MAP_BITS = 64;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned CURSOR_W = 7;

   localparam logic [2:0] OP_CLEAR_ALL = 3'd0;
   localparam logic [2:0] OP_RESTART   = 3'd1;
   localparam logic [2:0] OP_NEXT      = 3'd2;
   localparam logic [2:0] OP_SET       = 3'd3;
   localparam logic [2:0] OP_CLEAR     = 3'd4;
   localparam logic [2:0] OP_READ      = 3'd5;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] addr;
   } req_type;

   typedef struct packed {
      logic [5:0] poll_addr;
      logic       bit_value;
   } rsp_type;

endpackage

FILE: design/aarp_engine.sv
// Active map, polling cursor and the combinational command logic that updates them.
module aarp_engine #(
   parameter int unsigned NUM_ADDR = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  aarp_pkg::req_type item,
   output aarp_pkg::rsp_type result
);

   logic [aarp_pkg::MAP_BITS-1:0] map_ff, map_in;
   logic [aarp_pkg::CURSOR_W-1:0] cursor_ff, cursor_in;

   logic                          addr_ok;
   logic [aarp_pkg::CURSOR_W-1:0] start;
   logic [aarp_pkg::MAP_BITS-1:0] pending;
   logic                          hit;
   logic [aarp_pkg::POS_W-1:0]    hit_pos;

   // An address is usable when it is below the table size and inside the map.
   assign addr_ok = ({1'b0, item.addr} < 9'(NUM_ADDR)) && (item.addr[7:6] == 2'b00);

   assign start   = cursor_ff + aarp_pkg::CURSOR_W'(1);
   assign pending = map_ff & ({aarp_pkg::MAP_BITS{1'b1}} << start[aarp_pkg::POS_W-1:0]);

   // Priority encoder: the lowest set bit of the masked map wins.
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int i = aarp_pkg::MAP_BITS - 1; i >= 0; i--) begin
         if (pending[i]) begin
            hit     = 1'b1;
            hit_pos = aarp_pkg::POS_W'(i);
         end
      end
   end

   always_comb begin
      map_in           = map_ff;
      cursor_in        = cursor_ff;
      result.poll_addr = '0;
      result.bit_value = 1'b0;
      case (item.opcode)
         aarp_pkg::OP_CLEAR_ALL: begin
            map_in    = '0;
            cursor_in = '0;
         end
         aarp_pkg::OP_RESTART: begin
            cursor_in = '0;
         end
         aarp_pkg::OP_NEXT: begin
            if (!start[aarp_pkg::CURSOR_W-1] && hit) begin
               cursor_in        = {1'b0, hit_pos};
               result.poll_addr = hit_pos;
            end else begin
               cursor_in = '0;
            end
         end
         aarp_pkg::OP_SET: begin
            if (addr_ok) begin
               map_in[item.addr[aarp_pkg::POS_W-1:0]] = 1'b1;
            end
         end
         aarp_pkg::OP_CLEAR: begin
            if (addr_ok) begin
               map_in[item.addr[aarp_pkg::POS_W-1:0]] = 1'b0;
            end
         end
         aarp_pkg::OP_READ: begin
            if (addr_ok) begin
               result.bit_value = map_ff[item.addr[aarp_pkg::POS_W-1:0]];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff    <= '0;
         cursor_ff <= '0;
      end else if (fire) begin
         map_ff    <= map_in;
         cursor_ff <= cursor_in;
      end
   end

`ifndef SYNTH
   // The cursor only ever holds a map position, never the end marker.
   a_cursor_in_map: assert property (@(posedge clock) disable iff (reset)
      cursor_ff[aarp_pkg::CURSOR_W-1] == 1'b0)
      else $error("poll cursor left the map");

   // A found address always points at a bit that was set.
   a_found_is_set: assert property (@(posedge clock) disable iff (reset)
      (fire && result.poll_addr != '0) |-> map_ff[result.poll_addr])
      else $error("poll returned an inactive address");

   // Only a read reports a map bit.
   a_bit_only_read: assert property (@(posedge clock) disable iff (reset)
      (fire && item.opcode != aarp_pkg::OP_READ) |-> result.bit_value == 1'b0)
      else $error("bit value driven by a non-read command");
`endif

endmodule

FILE: design/active_address_round_robin_poller.sv
// Top level of the active address round-robin poller: command and response registers.
//
// Usage: commands arrive on the req_ channel as one transfer each, carrying an
// opcode and an address. Every command gives exactly one transfer on the rsp_
// channel: poll_addr holds the address found by a next command (zero when the
// round has ended), bit_value the map bit returned by a read.
// An accepted request transfer passes through the command register, where the map
// and cursor are updated, and then the response register before the response is
// valid. Throughput is one command per cycle while rsp_stall is low; the limit is
// the single pass through the 64-bit masked priority encoder. Reset empties the
// map, zeroes the cursor and discards any command or response in flight. When
// the receiver raises rsp_stall the response is held; a further command may
// still be taken into the command register, after which req_stall rises until
// the response transfer completes.
module active_address_round_robin_poller #(
   parameter int unsigned NUM_ADDR = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aarp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aarp_pkg::rsp_type rsp_data
);

   logic              cmd_valid_ff, cmd_valid_in;
   aarp_pkg::req_type cmd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   aarp_pkg::rsp_type rsp_ff;

   aarp_pkg::rsp_type result;
   logic              out_free;
   logic              fire;

   // The response register can take a new value when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // The held command executes as it moves into the response register.
   assign fire     = cmd_valid_ff && out_free;
   assign req_stall = cmd_valid_ff && !out_free;

   assign cmd_valid_in = req_stall ? cmd_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? cmd_valid_ff : rsp_valid_ff;

   aarp_engine #(
      .NUM_ADDR(NUM_ADDR)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (cmd_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only on a transfer, so a stalled value stays put.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
